FILE: rtl/wdad_pkg.sv
// Package for the wind direction gap block: widths, arctangent table and CORDIC helpers.
package wdad_pkg;

	localparam int WIND_WIDTH      = 16;
	localparam int ANGLE_FRAC_BITS = 6;
	localparam int CORDIC_STEPS    = 16;

	localparam int ATAN_LEN     = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int PRESCALE     = 24;
	localparam int MIN_WIND_W   = 15;

	// Vector width: prescaled input plus room for CORDIC gain and sign
	localparam int XY_W  = WIND_WIDTH + PRESCALE + 4;
	// Internal angle in 2^-16 degree, signed
	localparam int Z_W   = 26;
	localparam int CMP_W = (WIND_WIDTH > MIN_WIND_W) ? WIND_WIDTH : MIN_WIND_W;

	localparam int TURN_W = ANGLE_FRAC_BITS + 9;
	localparam int GAP_W  = ANGLE_FRAC_BITS + 8;

	localparam int FULL_TURN   = 360 << ANGLE_FRAC_BITS;
	localparam int HALF_TURN_Z = 180 * 65536;
	localparam int ROUND_ADD   = 1 << (15 - ANGLE_FRAC_BITS);
	localparam int ROUND_SHIFT = 16 - ANGLE_FRAC_BITS;

	typedef logic signed [WIND_WIDTH-1:0] wind_t;
	typedef logic [TURN_W-1:0]            turn_t;
	typedef logic [GAP_W-1:0]             gap_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} cordic_t;

	// atan(2^-i) in 2^-16 degree, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_val(input int i);
		logic signed [Z_W-1:0] v;
		case (i)
			0:  v = Z_W'(2949120);
			1:  v = Z_W'(1740967);
			2:  v = Z_W'(919879);
			3:  v = Z_W'(466945);
			4:  v = Z_W'(234379);
			5:  v = Z_W'(117304);
			6:  v = Z_W'(58666);
			7:  v = Z_W'(29335);
			8:  v = Z_W'(14668);
			9:  v = Z_W'(7334);
			10: v = Z_W'(3667);
			11: v = Z_W'(1833);
			12: v = Z_W'(917);
			13: v = Z_W'(458);
			14: v = Z_W'(229);
			15: v = Z_W'(115);
			16: v = Z_W'(57);
			17: v = Z_W'(29);
			18: v = Z_W'(14);
			19: v = Z_W'(7);
			20: v = Z_W'(4);
			21: v = Z_W'(2);
			22: v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Build the vector (-north, -east), fold the left half plane onto the right
	function automatic cordic_t cordic_init(input wind_t east, input wind_t north);
		logic signed [XY_W-1:0] e;
		logic signed [XY_W-1:0] n;
		cordic_t c;
		e = XY_W'(east) <<< PRESCALE;
		n = XY_W'(north) <<< PRESCALE;
		c.zero = (east == '0) && (north == '0);
		if (n > 0) begin
			c.x = n;
			c.y = e;
			c.z = Z_W'(HALF_TURN_Z);
		end else begin
			c.x = -n;
			c.y = -e;
			c.z = '0;
		end
		return c;
	endfunction

	// One vectoring rotation; arithmetic shift gives floor rounding
	function automatic cordic_t cordic_step(input cordic_t c, input int i);
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;
		cordic_t r;
		xs = c.x >>> i;
		ys = c.y >>> i;
		r.zero = c.zero;
		if (!c.y[XY_W-1]) begin
			r.x = c.x + ys;
			r.y = c.y - xs;
			r.z = c.z + atan_val(i);
		end else begin
			r.x = c.x - ys;
			r.y = c.y + xs;
			r.z = c.z - atan_val(i);
		end
		return r;
	endfunction

	// Round the angle to output units and wrap into one turn
	function automatic turn_t dir_round(input cordic_t c);
		logic signed [Z_W-1:0] r;
		r = (c.z + Z_W'(ROUND_ADD)) >>> ROUND_SHIFT;
		if (r < 0) begin
			r = r + Z_W'(FULL_TURN);
		end else if (r >= Z_W'(FULL_TURN)) begin
			r = r - Z_W'(FULL_TURN);
		end
		return c.zero ? '0 : r[TURN_W-1:0];
	endfunction

endpackage

FILE: rtl/wind_direction_angle_difference_top.sv
// Wind direction gap: two pipelined CORDIC vectoring units and a wrap-around difference.
//
//  channel | signals                                          | dir | handshake
//  --------+--------------------------------------------------+-----+-----------------
//  in      | obs_east obs_north model_east model_north        | in  | in_valid/in_stall
//          | obs_absent                                       |     |
//  out     | angle_gap gap_missing                            | out | out_valid/out_stall
//  cfg     | cfg_min_wind                                     | in  | cfg_valid/cfg_ready
//
// One item per cycle while out_stall is low; the path runs through the input and pre-rotation
// stages, one register per CORDIC rotation, rounding and output.
// Every stage has its own valid bit and loads when empty or when the next stage moves,
// so bubbles close up and an item enters while a finished result waits.
// arst_n clears valid bits and sets the calm threshold to 1; cfg_ready is always high.
module wind_direction_angle_difference_top
	import wdad_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  wind_t                  obs_east,
	input  wind_t                  obs_north,
	input  wind_t                  model_east,
	input  wind_t                  model_north,
	input  logic                   obs_absent,
	output logic                   out_valid,
	input  logic                   out_stall,
	output gap_t                   angle_gap,
	output logic                   gap_missing,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [MIN_WIND_W-1:0]  cfg_min_wind
);

	localparam int N = CORDIC_ITERS;

	logic [MIN_WIND_W-1:0] min_wind_q;

	// stage 1: captured inputs
	logic  v_s1, miss_s1;
	wind_t oe_s1, on_s1, me_s1, mn_s1;
	// stage 2: index 0 after pre-rotation, index k after rotation k
	logic    v_s2    [0:N];
	logic    miss_s2 [0:N];
	logic    calm_s2 [0:N];
	cordic_t obs_s2  [0:N];
	cordic_t mod_s2  [0:N];
	logic    en_s2   [0:N];
	// stage 3: rounded directions
	logic  v_s3, miss_s3, calm_s3;
	turn_t dobs_s3, dmod_s3;
	// stage 4: output register
	logic  v_s4, miss_s4;
	gap_t  gap_s4;

	logic en_s1, en_s3, en_s4;
	logic [MIN_WIND_W-1:0] thr;
	logic [WIND_WIDTH-1:0] mag_e, mag_n;
	logic                  calm;
	logic [TURN_W:0]       diff;
	turn_t                 dwrap, dalt, gap_next;

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_wind_q <= MIN_WIND_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			min_wind_q <= cfg_min_wind;
		end
	end

	// Stage enables: load when empty or when the next stage advances
	assign en_s4 = !v_s4 || !out_stall;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2[N] = !v_s2[N] || en_s3;
	for (genvar k = 0; k < N; k++) begin : g_en
		assign en_s2[k] = !v_s2[k] || en_s2[k+1];
	end
	assign en_s1 = !v_s1 || en_s2[0];
	assign in_stall = !en_s1;

	// Stage 1: capture item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en_s1) begin
			oe_s1   <= obs_east;
			on_s1   <= obs_north;
			me_s1   <= model_east;
			mn_s1   <= model_north;
			miss_s1 <= obs_absent;
		end
	end

	// Calm test against the threshold, zero read as one
	assign thr   = (min_wind_q == '0) ? MIN_WIND_W'(1) : min_wind_q;
	assign mag_e = oe_s1[WIND_WIDTH-1] ? WIND_WIDTH'(-oe_s1) : WIND_WIDTH'(oe_s1);
	assign mag_n = on_s1[WIND_WIDTH-1] ? WIND_WIDTH'(-on_s1) : WIND_WIDTH'(on_s1);
	assign calm  = (CMP_W'(mag_e) < CMP_W'(thr)) && (CMP_W'(mag_n) < CMP_W'(thr));

	// Stage 2 entry: pre-rotate both vectors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2[0] <= 1'b0;
		end else if (en_s2[0]) begin
			v_s2[0] <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en_s2[0]) begin
			miss_s2[0] <= miss_s1;
			calm_s2[0] <= calm;
			obs_s2[0]  <= cordic_init(oe_s1, on_s1);
			mod_s2[0]  <= cordic_init(me_s1, mn_s1);
		end
	end

	// CORDIC rotations, one register per step
	for (genvar k = 1; k <= N; k++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (en_s2[k]) begin
				v_s2[k] <= v_s2[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en_s2[k]) begin
				miss_s2[k] <= miss_s2[k-1];
				calm_s2[k] <= calm_s2[k-1];
				obs_s2[k]  <= cordic_step(obs_s2[k-1], k - 1);
				mod_s2[k]  <= cordic_step(mod_s2[k-1], k - 1);
			end
		end
	end

	// Stage 3: round and wrap both directions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2[N];
		end
	end
	always_ff @(posedge clk) begin
		if (en_s3) begin
			miss_s3 <= miss_s2[N];
			calm_s3 <= calm_s2[N];
			dobs_s3 <= dir_round(obs_s2[N]);
			dmod_s3 <= dir_round(mod_s2[N]);
		end
	end

	// Smallest gap around the circle
	always_comb begin
		diff = {1'b0, dobs_s3} - {1'b0, dmod_s3};
		if (diff[TURN_W]) begin
			diff = diff + (TURN_W + 1)'(FULL_TURN);
		end
		dwrap = diff[TURN_W-1:0];
		dalt  = TURN_W'(FULL_TURN) - dwrap;
		gap_next = (dalt < dwrap) ? dalt : dwrap;
	end

	// Stage 4: output register, absent and calm force zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en_s4) begin
			miss_s4 <= miss_s3;
			gap_s4  <= (miss_s3 || calm_s3) ? '0 : gap_next[GAP_W-1:0];
		end
	end

	assign out_valid   = v_s4;
	assign angle_gap   = gap_s4;
	assign gap_missing = miss_s4;

`ifndef SYNTHESIS
	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gap_missing |-> angle_gap == '0)
		else $error("missing result carries a nonzero gap");

	a_gap_half_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_gap <= GAP_W'(FULL_TURN / 2))
		else $error("gap beyond half a turn");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with an empty first stage");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en_s3 |-> v_s4 && out_stall)
		else $error("rounding stage held without output backpressure");

	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> dobs_s3 < TURN_W'(FULL_TURN) && dmod_s3 < TURN_W'(FULL_TURN))
		else $error("direction outside one turn");
`endif

endmodule
